// ----- hdl/idt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_pkg: shared types and constants for the ISO date text converter
// Holds the controller/datapath command and status bundles, the calendar
// constants and the small month tables.
// ----------------------------------------------------------------------------
package idt_pkg;

  localparam int unsigned POS_W       = 4;
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned MD_W        = 7;
  localparam int unsigned YOE_W       = 9;
  localparam int unsigned QUO_W       = 5;
  localparam int unsigned DAY_W       = 23;
  localparam int unsigned SUM_W       = 24;
  localparam int unsigned DIV_STEPS   = 2;
  localparam int unsigned STEP_W      = 1;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + QUO_W;

  localparam logic [POS_W-1:0] POS_SAT   = 4'd11;
  localparam logic [POS_W-1:0] POS_DASH1 = 4'd4;
  localparam logic [POS_W-1:0] POS_DASH2 = 4'd7;
  localparam logic [POS_W-1:0] POS_LAST  = 4'd9;
  localparam logic [POS_W-1:0] POS_END   = 4'd10;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DASH = 8'h2D;

  localparam logic [YEAR_W-1:0] ERA_YEARS     = 14'd400;
  // Rounded-up 2^22 / 400: the quotient is exact for every dividend below 43690.
  localparam logic [YEAR_W-1:0] ERA_RECIP     = 14'd10486;
  localparam logic [17:0]       DAYS_PER_YEAR = 18'd365;
  localparam logic [22:0]       DAYS_PER_ERA  = 23'd146097;
  // Epoch offset plus one era, because the era count runs one high.
  localparam logic [SUM_W-1:0]  EPOCH_BIAS    = 24'd865565;

  typedef struct packed {
    logic              acc;        // take one character
    logic              start;      // character was the last: capture and clear
    logic              div_step;   // one division step
    logic              div_fold;   // second step: fold the quotient back
    logic              mul_en;     // register the products
    logic              sum_en;     // register the final sum
    logic              load_out;   // move the result into the output register
  } idt_cmd_t;

  typedef struct packed {
    logic out_free;                // output register can take a result
  } idt_stat_t;

  // Day of the March-based year on which each shifted month begins.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [MD_W-1:0] month_len(input logic [MD_W-1:0] m,
                                                input logic leap);
    logic [MD_W-1:0] v;
    case (m)
      7'd2:                           v = leap ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:        v = 7'd30;
      default:                        v = 7'd31;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/idt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_ctrl: sequencer for the date converter
// Accepts characters, then steps the datapath through division, product,
// sum and output load.
// ----------------------------------------------------------------------------
module idt_ctrl
  import idt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tlast,
  output logic      in_tready,
  input  idt_stat_t stat,
  output idt_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_COLLECT = 5'b00001,
    ST_DIV     = 5'b00010,
    ST_MUL     = 5'b00100,
    ST_SUM     = 5'b01000,
    ST_LOAD    = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              take;

  assign in_tready = (state_r == ST_COLLECT);
  assign take      = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    unique case (state_r)
      ST_COLLECT: begin
        cmd.acc = take;
        if (take && in_tlast) begin
          cmd.start = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_fold = (step_r == STEP_W'(DIV_STEPS - 1));
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ----- hdl/idt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_datapath: character accumulators and day-number arithmetic
// Parses digits into year, month and day, divides by the 400-year era,
// forms the day count and holds the output register.
// ----------------------------------------------------------------------------
module idt_datapath
  import idt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] ch,
  input  idt_cmd_t   cmd,
  output idt_stat_t  stat,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [DAY_W-1:0] out_day,
  output logic       out_status
);

  // Parse state
  logic [POS_W-1:0]  pos_r;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [MD_W-1:0]   mon_r, mon_nxt;
  logic [MD_W-1:0]   day_r, day_nxt;
  logic              fbad_r, fbad_nxt;
  logic              digit;
  logic [3:0]        dv;

  // Captured date
  logic [MD_W-1:0]   cm_r;
  logic [MD_W-1:0]   cd_r;
  logic              fmt_ok_r;
  logic              m_le2;

  // Division by 400
  logic [YEAR_W-1:0]  rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic [RECIP_W-1:0] recip_prod;

  // Products and sum
  logic [17:0]       p1_r;
  logic [22:0]       p2_r;
  logic [10:0]       part_r, part_nxt;
  logic              valid_r, valid_nxt;
  logic [YOE_W-1:0]  yoe;
  logic [YOE_W-1:0]  ryr;
  logic [1:0]        hundreds;
  logic [3:0]        mp;
  logic              leap;
  logic [SUM_W-1:0]  sum;
  logic [DAY_W-1:0]  res_day_r;
  logic              res_ok_r;

  // Output register
  logic              out_valid_r;
  logic [DAY_W-1:0]  out_day_r;
  logic              out_status_r;

  assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dv    = digit ? ch[3:0] : 4'd0;

  always_comb begin
    year_nxt = year_r;
    mon_nxt  = mon_r;
    day_nxt  = day_r;
    fbad_nxt = fbad_r;
    if (pos_r >= POS_END) begin
      fbad_nxt = 1'b1;
    end else if (pos_r == POS_DASH1 || pos_r == POS_DASH2) begin
      if (ch != CH_DASH) fbad_nxt = 1'b1;
    end else if (!digit) begin
      fbad_nxt = 1'b1;
    end else if (pos_r < POS_DASH1) begin
      year_nxt = (year_r << 3) + (year_r << 1) + YEAR_W'(dv);
    end else if (pos_r < POS_DASH2) begin
      mon_nxt = (mon_r << 3) + (mon_r << 1) + MD_W'(dv);
    end else begin
      day_nxt = (day_r << 3) + (day_r << 1) + MD_W'(dv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      year_r <= '0;
      mon_r  <= '0;
      day_r  <= '0;
      fbad_r <= 1'b0;
    end else if (cmd.start) begin
      pos_r  <= '0;
      year_r <= '0;
      mon_r  <= '0;
      day_r  <= '0;
      fbad_r <= 1'b0;
    end else if (cmd.acc) begin
      if (pos_r < POS_SAT) pos_r <= pos_r + POS_W'(1);
      year_r <= year_nxt;
      mon_r  <= mon_nxt;
      day_r  <= day_nxt;
      fbad_r <= fbad_nxt;
    end
  end

  // Capture the finished date and seed the divider with year + 400 - (m <= 2)
  assign m_le2      = (cm_r <= MD_W'(2));
  // Quotient by reciprocal multiplication; the seeded year never exceeds 10399
  assign recip_prod = RECIP_W'(rem_r) * RECIP_W'(ERA_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cm_r     <= mon_nxt;
      cd_r     <= day_nxt;
      fmt_ok_r <= (pos_r == POS_LAST) && !fbad_nxt;
      rem_r    <= year_nxt + ERA_YEARS - YEAR_W'((mon_nxt <= MD_W'(2)) ? 1 : 0);
      quo_r    <= '0;
    end else if (cmd.div_step) begin
      if (cmd.div_fold) begin
        rem_r <= rem_r - YEAR_W'(quo_r) * ERA_YEARS;
      end else begin
        quo_r <= recip_prod[RECIP_W-1:RECIP_SHIFT];
      end
    end
  end

  // Year of era, leap test on the written year, day of era pieces
  assign yoe      = rem_r[YOE_W-1:0];
  assign hundreds = 2'((yoe >= YOE_W'(100)) ? 1 : 0) + 2'((yoe >= YOE_W'(200)) ? 1 : 0)
                  + 2'((yoe >= YOE_W'(300)) ? 1 : 0);
  assign ryr      = !m_le2 ? yoe : ((yoe == YOE_W'(399)) ? '0 : yoe + YOE_W'(1));
  assign leap     = (ryr[1:0] == 2'd0) && !(ryr == YOE_W'(100) || ryr == YOE_W'(200)
                                           || ryr == YOE_W'(300));
  assign mp       = m_le2 ? (cm_r[3:0] + 4'd9) : (cm_r[3:0] - 4'd3);

  always_comb begin
    part_nxt  = 11'(yoe >> 2) - 11'(hundreds) + 11'(month_start(mp))
              + 11'(cd_r) - 11'd1;
    valid_nxt = fmt_ok_r && (cm_r >= MD_W'(1)) && (cm_r <= MD_W'(12))
              && (cd_r >= MD_W'(1)) && (cd_r <= month_len(cm_r, leap));
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p1_r    <= 18'(yoe) * DAYS_PER_YEAR;
      p2_r    <= 23'(quo_r) * DAYS_PER_ERA;
      part_r  <= part_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign sum = SUM_W'(p2_r) + SUM_W'(p1_r) + SUM_W'(part_r) - EPOCH_BIAS;

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      res_day_r <= valid_r ? sum[DAY_W-1:0] : '0;
      res_ok_r  <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_day_r    <= res_day_r;
      out_status_r <= !res_ok_r;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_day       = out_day_r;
  assign out_status    = out_status_r;

endmodule

// ----- hdl/iso_date_text_to_day_number.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_date_text_to_day_number: YYYY-MM-DD text to signed day count
// Streams a date one character per transaction and returns the day number
// relative to 1970-01-01 together with a valid/invalid status.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the block collects a date; the
// transaction carrying tlast closes the text and produces exactly one result
// transaction. After that last character the input stalls while the era
// division by 400 runs as a reciprocal multiplication for the quotient, then
// a fold-back that leaves the year of era, followed by the product state for
// the year and era products, the sum state for the final sum and the load
// state that moves the result into the output register. A result still
// waiting in the output register holds the block in the load state until it
// is taken; characters of the next date are accepted as soon as the result is
// loaded. A text that is not exactly ten characters, lacks a dash at position
// 4 or 7, has a non-digit elsewhere, or names a month or day outside the
// calendar gives status 1 and day number 0.
// ----------------------------------------------------------------------------
module iso_date_text_to_day_number
  import idt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // last character of the date text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [22:0] day_number (signed), [23] status
);

  idt_cmd_t         cmd;
  idt_stat_t        stat;
  logic [DAY_W-1:0] out_day;
  logic             out_status;

  // Sequence accept, divide, multiply, sum and load
  idt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Parse characters and compute the day count
  idt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ch         (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_day    (out_day),
    .out_status (out_status)
  );

  assign out_tdata = {out_status, out_day};

endmodule

// ----- hdl/idt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_checker: port-level checks for the date converter
// Watches the stream ports and flags result and sequencing slips.
// ----------------------------------------------------------------------------
module idt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // Invalid status always carries a zero day number
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[23] || out_tdata[22:0] == 23'd0))
    else $error("invalid result with nonzero day number");

  // Stop taking characters while a date is converted
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("character accepted during conversion");

  // No new result straight after the closing character; only a stalled older one may be held
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !out_tvalid || $past(out_tvalid) && !$past(out_tready))
    else $error("result appeared too soon after last character");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind iso_date_text_to_day_number idt_checker u_idt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/tb_iso_date_text_to_day_number.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iso_date_text_to_day_number: self-checking bench for the date converter
// Streams YYYY-MM-DD texts, well formed, out of range, corrupted and pure
// noise, into the block with random gaps on both sides. A scoreboard class
// predicts the day number and status of each text and checks every result
// transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_iso_date_text_to_day_number;
  import idt_pkg::*;

  // Cycles with no transaction on either side before the run is declared hung.
  // A result costs only the conversion states plus random stalls, so this is generous.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Settle time after the last result.
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CHAR_TARGET  = 1500;

  // Result transaction layout: status on top, day number below.
  typedef struct packed {
    logic             status;
    logic [DAY_W-1:0] days;
  } date_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the text being parsed and queues the expected result.
  // --------------------------------------------------------------------------
  class date_scoreboard;
    logic [POS_W-1:0]  pos;
    logic [YEAR_W-1:0] year;
    logic [MD_W-1:0]   month;
    logic [MD_W-1:0]   dom;
    logic              bad;
    date_result_t      pending_q[$];
    int unsigned       errors;
    int unsigned       valid_seen;
    int unsigned       invalid_seen;

    function new();
      errors       = 0;
      valid_seen   = 0;
      invalid_seen = 0;
      restart();
    endfunction

    function void restart();
      pos   = '0;
      year  = '0;
      month = '0;
      dom   = '0;
      bad   = 1'b0;
    endfunction

    function int days_in_month(int y, int m);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
        2:             return leap ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    // March-based year, 400-year eras, epoch 1970-01-01.
    function longint civil_to_days(longint y, longint m, longint d);
      longint era;
      longint yoe;
      longint doy;
      longint doe;
      if (m <= 2) y = y - 1;
      era = (y >= 0) ? y / 400 : (y - 399) / 400;
      yoe = y - era * 400;
      doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
    endfunction

    // Note one accepted character; on the last one, queue its result.
    function void note_char(logic [7:0] ch, logic last);
      logic [POS_W-1:0] p;
      logic [3:0]       dv;
      bit               digit;
      bit               good;
      date_result_t     r;
      p     = pos;
      digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      dv    = digit ? 4'(ch - CH_ZERO) : 4'd0;
      if (p >= POS_END) begin
        bad = 1'b1;
      end else if (p == POS_DASH1 || p == POS_DASH2) begin
        if (ch != CH_DASH) bad = 1'b1;
      end else if (!digit) begin
        bad = 1'b1;
      end else if (p < POS_DASH1) begin
        year = YEAR_W'(year * 10 + dv);
      end else if (p < POS_DASH2) begin
        month = MD_W'(month * 10 + dv);
      end else begin
        dom = MD_W'(dom * 10 + dv);
      end
      if (pos < POS_SAT) pos = pos + 1'b1;
      if (!last) return;
      good = (p == POS_LAST) && !bad && (month >= 1) && (month <= 12) && (dom >= 1)
             && (dom <= days_in_month(int'(year), int'(month)));
      r.status = !good;
      r.days   = good ? DAY_W'(civil_to_days(longint'(year), longint'(month),
                                             longint'(dom)))
                      : '0;
      pending_q.push_back(r);
      restart();
    endfunction

    // Compare one result transaction with the oldest expectation.
    function void check_result(logic [DAY_W:0] data);
      date_result_t got;
      date_result_t want;
      got = data;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, actual %h", $time, data);
        return;
      end
      want = pending_q.pop_front();
      if (got.days !== want.days) begin
        errors++;
        $display("%0t: day_number mismatch, expected %0d actual %0d", $time,
                 $signed(want.days), $signed(got.days));
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %b actual %b", $time,
                 want.status, got.status);
      end
      if (want.status) invalid_seen++;
      else valid_seen++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and bench state
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [DAY_W:0]   out_tdata;

  date_scoreboard   sb;
  logic [7:0]       text_q[$];
  bit               quiet;        // suppress idling on both sides
  int unsigned      chars_sent;
  int unsigned      texts_sent;
  int unsigned      idle_cycles;

  always #5 clk = ~clk;

  iso_date_text_to_day_number i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Stall the result side about a third of the time, except in quiet stretches.
  always @(negedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 34);
  end

  // Sample both channels at the rising edge; feed the scoreboard and
  // run the watchdog on cycles where neither side moves a transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("tb_iso_date_text_to_day_number failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers: called at a falling edge, return at a falling edge
  // --------------------------------------------------------------------------

  // Offer one character, with a random gap first, and hold until taken.
  task automatic send_char(logic [7:0] ch, logic last);
    while (!quiet && ($urandom_range(99) < 34)) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = ch;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  // Send the text in text_q, flagging its final character.
  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    texts_sent++;
  endtask

  task automatic load_str(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_str(string s);
    load_str(s);
    send_text();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned yr;
    int unsigned mon;
    int unsigned dd;
    int unsigned kind;

    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    quiet       = 1'b0;
    chars_sent  = 0;
    texts_sent  = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: epoch, range ends, leap rules, field limits, format errors.
    send_str("1970-01-01");
    send_str("0000-01-01");
    send_str("9999-12-31");
    send_str("0000-02-29");   // year zero counts as a leap year
    send_str("2000-02-29");
    send_str("1900-02-29");   // century, not a leap year
    send_str("2024-02-29");
    send_str("2023-02-29");
    send_str("1969-12-31");
    send_str("2021-04-31");
    send_str("2021-00-10");
    send_str("2021-13-10");
    send_str("2021-06-00");
    send_str("2021-01-32");
    send_str("2021/01-05");
    send_str("2021-01/05");
    send_str("20a1-01-05");
    send_str("2021-01-050");  // one character too many
    send_str("2021-01-05-99999"); // runs well past position saturation
    send_str("2021-01-5");    // one short
    send_str("7");
    // Drive every data bit both ways.
    text_q = '{8'h00, 8'hFF};
    send_text();
    load_str("1999-12-3");
    text_q.push_back(8'hFF);
    send_text();

    // Random: mostly well-formed dates, then range errors, corruption,
    // wrong lengths and noise. One stretch runs with no idling at all.
    while (chars_sent < CHAR_TARGET) begin
      quiet = (texts_sent >= 60) && (texts_sent < 90);
      case ($urandom_range(7))
        0:       yr = $urandom_range(1) ? 0 : 9999;
        1:       yr = $urandom_range(1) ? 1900 + 100 * $urandom_range(1) : 1970;
        2:       yr = $urandom_range(1, 3);
        default: yr = $urandom_range(9999);
      endcase
      mon  = $urandom_range(1, 12);
      dd   = $urandom_range(1, 31);
      kind = $urandom_range(99);
      if (kind < 15) begin
        mon = $urandom_range(99);
        dd  = $urandom_range(99);
      end
      load_str($sformatf("%04d-%02d-%02d", yr, mon, dd));
      if (kind >= 70 && kind < 80) begin
        text_q[$urandom_range(9)] = 8'($urandom_range(255));
      end else if (kind >= 80 && kind < 87) begin
        repeat ($urandom_range(1, 9)) void'(text_q.pop_back());
      end else if (kind >= 87 && kind < 93) begin
        repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(255)));
      end else if (kind >= 93) begin
        text_q.delete();
        repeat ($urandom_range(1, 14)) begin
          text_q.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                    : 8'(CH_ZERO + $urandom_range(9)));
        end
      end
      send_text();
    end
    in_tvalid = 1'b0;
    quiet     = 1'b0;

    // Drain: wait for every expected result, then let the pipeline settle.
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d texts; checked %0d valid dates and %0d rejects.",
             chars_sent, texts_sent, sb.valid_seen, sb.invalid_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_iso_date_text_to_day_number passed");
    end else begin
      $display("tb_iso_date_text_to_day_number failed");
    end
    $finish;
  end

endmodule

// ----- iso_date_text_to_day_number.f -----
hdl/idt_pkg.sv
hdl/idt_ctrl.sv
hdl/idt_datapath.sv
hdl/iso_date_text_to_day_number.sv
hdl/idt_checker.sv
sim/tb_iso_date_text_to_day_number.sv
